// File: rtl/core/mtte_pkg.sv
// shared types, codes and key tables for the multi-tap text entry editor
package mtte_pkg;

  localparam int unsigned TEXT_CAPACITY_DEF = 45;

  // operation codes of an input item
  localparam logic [1:0] OP_PRESS  = 2'd0;
  localparam logic [1:0] OP_COMMIT = 2'd1;

  // editing keys sit in column 3
  localparam logic [1:0] COL_EDIT  = 2'd3;
  localparam logic [1:0] ROW_LEFT  = 2'd0;
  localparam logic [1:0] ROW_BKSP  = 2'd1;
  localparam logic [1:0] ROW_CLEAR = 2'd2;
  localparam logic [1:0] ROW_RIGHT = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [1:0] key_row;
    logic [1:0] key_col;
    logic [5:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic [5:0] cursor_pos;
    logic [5:0] char_count;
    logic       pending_flag;
    logic [1:0] pending_choice;
  } out_item_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_CYCLE,
    ACT_INSERT,
    ACT_BKSP,
    ACT_LEFT,
    ACT_RIGHT,
    ACT_CLEAR
  } act_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SHIFT_UP,
    ST_INSERT,
    ST_SHIFT_DN,
    ST_READ,
    ST_RESULT
  } ctl_state_e;

  typedef struct packed {
    logic load;
    logic apply;
    logic step_up;
    logic step_dn;
    logic ins_wr;
    logic bk_fin;
    logic rd_issue;
    logic res_load;
  } ctl_cmd_t;

  // up_done and dn_done: the shift pointer has issued its last move
  // mv_busy: a move is still waiting for its ram write
  typedef struct packed {
    act_e act;
    logic up_done;
    logic dn_done;
    logic mv_busy;
    logic res_free;
  } dp_status_t;

  // letters of a key, first letter in the top byte; key = row*4 + col
  function automatic logic [31:0] key_letters(logic [3:0] key);
    logic [31:0] row;
    case (key)
      4'd0:    row = {"1", 24'h0};
      4'd1:    row = "abc2";
      4'd2:    row = "def3";
      4'd4:    row = "ghi4";
      4'd5:    row = "jkl5";
      4'd6:    row = "mno6";
      4'd8:    row = "prs7";
      4'd9:    row = "tuv8";
      4'd10:   row = "wxy9";
      4'd12:   row = {"*", 24'h0};
      4'd13:   row = {" 0", 16'h0};
      4'd14:   row = {"#", 24'h0};
      default: row = 32'h0;
    endcase
    return row;
  endfunction

  function automatic logic [7:0] key_char(logic [3:0] key, logic [1:0] sel);
    logic [31:0] row;
    row = key_letters(key);
    return row[{~sel, 3'b000} +: 8];
  endfunction

  function automatic logic [2:0] key_len(logic [3:0] key);
    logic [2:0] len;
    case (key)
      4'd0, 4'd12, 4'd14:                  len = 3'd1;
      4'd13:                               len = 3'd2;
      4'd1, 4'd2, 4'd4, 4'd5, 4'd6,
      4'd8, 4'd9, 4'd10:                   len = 3'd4;
      default:                             len = 3'd0;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/core/multitap_text_entry_editor.sv
// multi-tap keypad text entry editor, top level
// sequence: decode, then a tail shift up and the letter write for an insert, or a tail shift
//   down for a backspace; every item ends with the read and the result load
// items are taken one at a time, a new one only after the last has loaded its result;
//   the tail shift moves one character per cycle through the single ram write port
// reset: asynchronous, clears cursor, count, pending letter and handshake state;
//   text ram is not swept, entries at or past the count read as zero
module multitap_text_entry_editor #(
  parameter int unsigned TextCapacity = mtte_pkg::TEXT_CAPACITY_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input item channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mtte_pkg::in_item_t  in_data_i,
  // result item channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mtte_pkg::out_item_t out_data_o
);
  import mtte_pkg::*;

  // command and status between the sequencer and the datapath
  ctl_cmd_t   cmd;
  dp_status_t status;

  // sequencer: takes one item at a time, walks the shift loop, then
  // issues the read for the reported character and loads the result
  mtte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath: cursor, count, pending letter, text ram and the result
  // register, which lets a finished item wait while the next one is taken
  mtte_dp #(
    .TextCapacity (TextCapacity)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/core/mtte_ram.sv
// generic single-write, single-read ram with registered read data
module mtte_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 45
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/mtte_ctrl.sv
// controller state machine: sequences decode, shift, insert, read and result
module mtte_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  mtte_pkg::dp_status_t status_i,
  output mtte_pkg::ctl_cmd_t   cmd_o
);
  import mtte_pkg::*;

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (status_i.act == ACT_INSERT) begin
          state_d = ST_SHIFT_UP;
        end else if (status_i.act == ACT_BKSP) begin
          state_d = ST_SHIFT_DN;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_SHIFT_UP: begin
        if (status_i.up_done && !status_i.mv_busy) state_d = ST_INSERT;
      end
      ST_INSERT: state_d = ST_READ;
      ST_SHIFT_DN: begin
        if (status_i.dn_done && !status_i.mv_busy) state_d = ST_READ;
      end
      ST_READ: state_d = ST_RESULT;
      ST_RESULT: begin
        if (status_i.res_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_DECODE:   cmd_o.apply    = 1'b1;
      ST_SHIFT_UP: cmd_o.step_up  = !status_i.up_done;
      ST_INSERT:   cmd_o.ins_wr   = 1'b1;
      ST_SHIFT_DN: begin
        cmd_o.step_dn = !status_i.dn_done;
        cmd_o.bk_fin  = status_i.dn_done && !status_i.mv_busy;
      end
      ST_READ:     cmd_o.rd_issue = 1'b1;
      ST_RESULT:   cmd_o.res_load = status_i.res_free;
      default:     cmd_o          = '0;
    endcase
  end

endmodule

// File: rtl/core/mtte_dp.sv
// datapath: editor state, text ram, shift pointer and result register
module mtte_dp #(
  parameter int unsigned TextCapacity = mtte_pkg::TEXT_CAPACITY_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mtte_pkg::in_item_t   in_data_i,
  input  mtte_pkg::ctl_cmd_t   cmd_i,
  output mtte_pkg::dp_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mtte_pkg::out_item_t  out_data_o
);
  import mtte_pkg::*;

  localparam int unsigned CntW = $clog2(TextCapacity);

  in_item_t   item_q;
  logic [CntW-1:0] cursor_q, cursor_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] ptr_q, ptr_d;
  logic            pend_valid_q, pend_valid_d;
  logic [3:0]      pend_key_q, pend_key_d;
  logic [1:0]      choice_q, choice_d;
  logic            mv_q, mv_d;
  logic [CntW-1:0] mv_dst_q, mv_dst_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q;

  logic [3:0]      key;
  logic [2:0]      len;
  logic [2:0]      pend_len;
  logic [1:0]      choice_nx;
  logic            same_key;
  logic            full;
  logic            commit;
  act_e            act;

  logic            ram_we;
  logic [CntW-1:0] ram_waddr;
  logic [7:0]      ram_wdata;
  logic            ram_re;
  logic [CntW-1:0] ram_raddr;
  logic [7:0]      ram_rdata;

  assign key       = {item_q.key_row, item_q.key_col};
  assign len       = key_len(key);
  assign pend_len  = key_len(pend_key_q);
  assign same_key  = pend_valid_q && (pend_key_q == key);
  assign full      = (32'(count_q) + 32'd1) >= 32'(TextCapacity);
  assign choice_nx = ((3'(choice_q) + 3'd1) >= pend_len) ? 2'd0 : choice_q + 2'd1;

  always_comb begin
    act = ACT_NONE;
    if (item_q.opcode == OP_PRESS) begin
      if (same_key) begin
        act = ACT_CYCLE;
      end else if (item_q.key_col == COL_EDIT) begin
        unique case (item_q.key_row)
          ROW_LEFT:  act = ACT_LEFT;
          ROW_BKSP:  act = (cursor_q != '0) ? ACT_BKSP : ACT_NONE;
          ROW_CLEAR: act = ACT_CLEAR;
          ROW_RIGHT: act = ACT_RIGHT;
          default:   act = ACT_NONE;
        endcase
      end else if (!full && len != 3'd0) begin
        act = ACT_INSERT;
      end
    end
  end

  assign commit = (item_q.opcode == OP_COMMIT) ||
                  ((item_q.opcode == OP_PRESS) && (act != ACT_CYCLE));

  always_comb begin
    cursor_d     = cursor_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    pend_valid_d = pend_valid_q;
    pend_key_d   = pend_key_q;
    choice_d     = choice_q;
    mv_d         = 1'b0;
    mv_dst_d     = mv_dst_q;
    if (cmd_i.apply) begin
      if (commit) begin
        pend_valid_d = 1'b0;
        pend_key_d   = '0;
        choice_d     = '0;
      end
      unique case (act)
        ACT_CYCLE: choice_d = choice_nx;
        ACT_LEFT: begin
          if (cursor_q != '0) cursor_d = cursor_q - 1'b1;
        end
        ACT_RIGHT: begin
          if (cursor_q < count_q) cursor_d = cursor_q + 1'b1;
        end
        ACT_CLEAR: begin
          cursor_d = '0;
          count_d  = '0;
        end
        ACT_BKSP: begin
          cursor_d = cursor_q - 1'b1;
          ptr_d    = cursor_q - 1'b1;
        end
        ACT_INSERT: begin
          ptr_d = count_q;
          if (len >= 3'd2) begin
            pend_valid_d = 1'b1;
            pend_key_d   = key;
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.step_up) begin
      ptr_d    = ptr_q - 1'b1;
      mv_d     = 1'b1;
      mv_dst_d = ptr_q;
    end
    if (cmd_i.step_dn) begin
      ptr_d    = ptr_q + 1'b1;
      mv_d     = 1'b1;
      mv_dst_d = ptr_q;
    end
    if (cmd_i.ins_wr) begin
      cursor_d = cursor_q + 1'b1;
      count_d  = count_q + 1'b1;
    end
    if (cmd_i.bk_fin) begin
      count_d = count_q - 1'b1;
    end
  end

  // one ram write per cycle: a move in flight, a cycled letter or an inserted one
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = mv_dst_q;
    ram_wdata = ram_rdata;
    if (mv_q) begin
      ram_we = 1'b1;
    end else if (cmd_i.apply && act == ACT_CYCLE) begin
      ram_we    = 1'b1;
      ram_waddr = cursor_q - 1'b1;
      ram_wdata = key_char(pend_key_q, choice_nx);
    end else if (cmd_i.ins_wr) begin
      ram_we    = 1'b1;
      ram_waddr = cursor_q;
      ram_wdata = key_char(key, 2'd0);
    end
  end

  always_comb begin
    ram_re    = cmd_i.step_up || cmd_i.step_dn || cmd_i.rd_issue;
    ram_raddr = CntW'(item_q.read_index);
    if (cmd_i.step_up) begin
      ram_raddr = ptr_q - 1'b1;
    end else if (cmd_i.step_dn) begin
      ram_raddr = ptr_q + 1'b1;
    end
  end

  mtte_ram #(
    .Width (8),
    .Depth (TextCapacity)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_d = cmd_i.res_load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q     <= '0;
      count_q      <= '0;
      ptr_q        <= '0;
      pend_valid_q <= 1'b0;
      pend_key_q   <= '0;
      choice_q     <= '0;
      mv_q         <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      cursor_q     <= cursor_d;
      count_q      <= count_d;
      ptr_q        <= ptr_d;
      pend_valid_q <= pend_valid_d;
      pend_key_q   <= pend_key_d;
      choice_q     <= choice_d;
      mv_q         <= mv_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mv_dst_q <= mv_dst_d;
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.res_load) begin
      // entries at or past the count are stale and read as zero
      out_q.read_char      <= (32'(item_q.read_index) < 32'(count_q)) ? ram_rdata : 8'd0;
      out_q.cursor_pos     <= 6'(cursor_q);
      out_q.char_count     <= 6'(count_q);
      out_q.pending_flag   <= pend_valid_q;
      out_q.pending_choice <= pend_valid_q ? choice_q : 2'd0;
    end
  end

  assign status_o.act      = act;
  assign status_o.up_done  = (ptr_q == cursor_q);
  assign status_o.dn_done  = (32'(ptr_q) + 32'd1) >= 32'(count_q);
  assign status_o.mv_busy  = mv_q;
  assign status_o.res_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_cursor_in_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= count_q)
    else $error("cursor beyond text end");

  a_count_below_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) < 32'(TextCapacity))
    else $error("count reached capacity");

  a_pending_has_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && pend_valid_q) |-> (cursor_q != '0))
    else $error("pending letter with cursor at start");

  a_move_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step_up || cmd_i.step_dn) |=> (mv_q && ram_we))
    else $error("shift move did not write");
`endif

endmodule
